// ===== sv/insertion_sorter_assert.svh =====
// ---------------------------------------------------------------------------
// insertion_sorter assertion macros
// Concurrent assertion wrappers on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ISORT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("insertion_sorter: same-cycle check failed");
// next-cycle implication
`define ISORT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("insertion_sorter: next-cycle check failed");
`else
`define ISORT_ASSERT_IMP(lbl, ante, cons)
`define ISORT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/isort_pkg.sv =====
// ---------------------------------------------------------------------------
// isort_pkg
// Shared types of the insertion sorter cell chain.
// ---------------------------------------------------------------------------
package isort_pkg;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;  // insert the broadcast value
        logic shl;  // shift contents one cell toward the output
    } t_cell_ctl;

endpackage

// ===== sv/insertion_sorter.sv =====
// ---------------------------------------------------------------------------
// insertion_sorter
// Stable insertion sort of one set of signed values in a chain of cells.
// ---------------------------------------------------------------------------
// Loading takes one value per cycle: every cell compares its entry with the
// incoming value in parallel and the greater entries move one cell up, so
// the insert time does not depend on the fill. After the transfer that
// carries final_item, input is held off while the chain shifts its N entries
// out of cell 0 at one result per cycle while the receiver is ready.
// Values arriving with all CAPACITY cells full are dropped and flagged as
// overflowed on every result of that run.
// ---------------------------------------------------------------------------
module insertion_sorter #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    input  logic               i_final_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_sorted_value,
    output logic               o_end_of_run,
    output logic               o_overflowed
);
    import isort_pkg::*;

    `include "insertion_sorter_assert.svh"

    logic [DATA_WIDTH-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_g;
    logic [63:0]           value_ext;
    logic [63:0]           out_ext;
    logic [DATA_WIDTH-1:0] value_dw;
    t_cell_ctl             ctl;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  full;
    logic                  r_draining;
    logic                  n_draining;
    logic                  r_dropped;
    logic                  n_dropped;

    assign value_ext = {32'b0, i_value};
    assign value_dw  = value_ext[DATA_WIDTH-1:0];
    assign out_ext   = 64'(cell_val[0]);

    assign full     = cell_valid[CAPACITY-1];
    assign o_ready  = !r_draining;
    assign in_xfer  = i_valid && o_ready;
    assign o_valid  = r_draining;
    assign out_xfer = o_valid && i_ready;

    assign ctl.ins = in_xfer && !full;
    assign ctl.shl = out_xfer;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            isort_cell #(
                .DW (DATA_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_value      (value_dw),
                .i_prev_val   ((gi == 0) ? value_dw : cell_val[(gi == 0) ? 0 : gi-1]),
                .i_prev_valid ((gi == 0) ? 1'b0 : cell_valid[(gi == 0) ? 0 : gi-1]),
                .i_prev_g     ((gi == 0) ? 1'b0 : cell_g[(gi == 0) ? 0 : gi-1]),
                .i_next_val   ((gi == CAPACITY-1) ? cell_val[gi]
                                                  : cell_val[(gi == CAPACITY-1) ? gi : gi+1]),
                .i_next_valid ((gi == CAPACITY-1) ? 1'b0
                                                  : cell_valid[(gi == CAPACITY-1) ? gi : gi+1]),
                .o_val        (cell_val[gi]),
                .o_valid      (cell_valid[gi]),
                .o_g          (cell_g[gi])
            );
        end
    endgenerate

    always_comb begin
        n_draining = r_draining;
        n_dropped  = r_dropped;
        if (in_xfer) begin
            if (full) begin
                n_dropped = 1'b1;
            end
            if (i_final_item) begin
                n_draining = 1'b1;
            end
        end
        if (out_xfer && o_end_of_run) begin
            n_draining = 1'b0;
            n_dropped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            r_draining <= n_draining;
            r_dropped  <= n_dropped;
        end
    end

    assign o_sorted_value = $signed(out_ext[31:0]);
    assign o_end_of_run   = !cell_valid[1];
    assign o_overflowed   = r_dropped;

    // occupied cells always form a prefix of the chain
    `ISORT_ASSERT_IMP(a_prefix, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0)
    // a presented result always comes from an occupied cell
    `ISORT_ASSERT_IMP(a_out_occupied, o_valid, cell_valid[0])
    // the end of a run leaves the chain empty and the drop flag clear
    `ISORT_ASSERT_NXT(a_run_clears, out_xfer && o_end_of_run,
                      cell_valid == '0 && !r_dropped && o_ready)

endmodule

// ===== sv/isort_cell.sv =====
// ---------------------------------------------------------------------------
// isort_cell
// One slot of the sorted chain: compare with the broadcast value, then hold,
// take the value, take the left neighbor's value, or shift in from the right.
// ---------------------------------------------------------------------------
module isort_cell #(
    parameter int DW = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  isort_pkg::t_cell_ctl i_ctl,
    input  logic [DW-1:0]      i_value,
    input  logic [DW-1:0]      i_prev_val,
    input  logic               i_prev_valid,
    input  logic               i_prev_g,
    input  logic [DW-1:0]      i_next_val,
    input  logic               i_next_valid,
    output logic [DW-1:0]      o_val,
    output logic               o_valid,
    output logic               o_g
);
    import isort_pkg::*;

    logic [DW-1:0] r_val;
    logic          r_valid;
    logic [DW-1:0] n_val;
    logic          n_valid;

    // empty slots count as greater, so the first empty slot takes the value
    assign o_g = !r_valid || ($signed(r_val) > $signed(i_value));

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        if (i_ctl.shl) begin
            n_val   = i_next_val;
            n_valid = i_next_valid;
        end else if (i_ctl.ins && o_g) begin
            // an empty left neighbor keeps this slot empty
            n_val   = i_prev_g ? i_prev_val : i_value;
            n_valid = i_prev_g ? i_prev_valid : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;

endmodule

// ===== tb/insertion_sorter_test.sv =====
// ---------------------------------------------------------------------------
// insertion_sorter_test
// Self-checking testbench for the streaming insertion sorter. Sets of signed
// values are pushed through the valid/ready input channel; a scoreboard keeps
// its own sorted copy of each set and checks every emitted result, its
// end-of-run mark and its overflow flag. Sets run from a single element up
// to past the store capacity, under three patterns of sender/receiver stalls.
// ---------------------------------------------------------------------------
module insertion_sorter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 64;
    localparam int PERIOD         = 12;
    localparam int TIMEOUT_CYCLES = 300000;
    localparam int PHASE_ITEMS    = 140;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               lost;
    } t_sort_result;

    // Keeps a sorted copy of the set being loaded and the results still due.
    class sort_scoreboard;
        logic signed [31:0] bank[$];
        bit                 lost;
        t_sort_result       awaited[$];
        int                 errors;
        int                 checked;
        int                 taken;
        int                 runs;
        int                 lossy_runs;

        // stable insert: new value goes behind every entry <= it
        function void take_element(logic signed [31:0] v, logic last);
            int           pos;
            t_sort_result r;
            taken++;
            if (bank.size() >= SLOTS) begin
                lost = 1'b1;
            end else begin
                pos = bank.size();
                while (pos > 0 && bank[pos-1] > v) pos--;
                bank.insert(pos, v);
            end
            if (last) begin
                foreach (bank[k]) begin
                    r.value = bank[k];
                    r.last  = (k == bank.size() - 1);
                    r.lost  = lost;
                    awaited.push_back(r);
                end
                runs++;
                if (lost) lossy_runs++;
                bank.delete();
                lost = 1'b0;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("[%0t] insertion_sorter mismatch: %s", $time, msg);
        endtask

        task match_output(logic signed [31:0] v, logic last, logic lost_flag);
            t_sort_result want;
            checked++;
            if (awaited.size() == 0) begin
                report($sformatf("result %0d with nothing expected", v));
                return;
            end
            want = awaited.pop_front();
            if (v !== want.value)
                report($sformatf("sorted_value %0d, expected %0d", v, want.value));
            if (last !== want.last)
                report($sformatf("end_of_run %b, expected %b (value %0d)", last, want.last,
                                 want.value));
            if (lost_flag !== want.lost)
                report($sformatf("overflowed %b, expected %b (value %0d)", lost_flag,
                                 want.lost, want.value));
        endtask
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic signed [31:0] i_value      = '0;
    logic               i_final_item = 1'b0;
    logic               i_ready      = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_sorted_value;
    logic               o_end_of_run;
    logic               o_overflowed;

    int snd_idle = 0;
    int rcv_idle = 0;

    sort_scoreboard sb = new();

    insertion_sorter #(
        .CAPACITY   (SLOTS),
        .DATA_WIDTH (32)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_value (o_sorted_value),
        .o_end_of_run   (o_end_of_run),
        .o_overflowed   (o_overflowed)
    );

    always begin
        #(PERIOD / 2) i_clk = 1'b1;
        #(PERIOD / 2) i_clk = 1'b0;
    end

    // Both channels are observed in one place so an input transfer is always
    // noted before any result it causes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.take_element(i_value, i_final_item);
            if (o_valid && i_ready) sb.match_output(o_sorted_value, o_end_of_run, o_overflowed);
        end
        i_ready <= ($urandom_range(99) >= rcv_idle);
    end

    initial begin
        #(TIMEOUT_CYCLES * PERIOD);
        $display("insertion_sorter: timeout, %0d results still due", sb.pending());
        $display("** insertion_sorter: FAILED **");
        $finish;
    end

    // Called at a clock edge; returns at the edge of the transfer with valid
    // still high, so back-to-back items follow with no gap.
    task automatic push_item(logic signed [31:0] v, logic last);
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_value      <= v;
        i_final_item <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(9)) inside
            0: begin
                case ($urandom_range(3))
                    0:       v = 32'sh7fff_ffff;
                    1:       v = 32'sh8000_0000;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            [1:3]: begin
                // narrow range gives plenty of equal keys
                v = $urandom_range(15);
                v = v - 32'sd8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 65) return $urandom_range(1, 8);
        if (r < 90) return $urandom_range(9, 40);
        if (r < 96) return $urandom_range(41, 63);
        return $urandom_range(SLOTS, SLOTS + 4);
    endfunction

    task automatic push_set(int count);
        for (int k = 0; k < count; k++) push_item(pick_value(), k == count - 1);
    endtask

    initial begin
        int left;
        int set_no;
        int count;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle = 12;
        rcv_idle = 52;

        // single-element set
        push_item(32'sd5, 1'b1);
        // extremes, duplicates and zero crossings in one set
        push_item(32'sh7fff_ffff, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sd0, 1'b0);
        push_item(-32'sd1, 1'b0);
        push_item(32'sd1, 1'b0);
        push_item(32'sh7fff_ffff, 1'b0);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sd7, 1'b0);
        push_item(32'sd7, 1'b0);
        push_item(-32'sd7, 1'b0);
        push_item(32'sd0, 1'b1);
        // strictly descending: every insert shifts the whole store
        for (int k = 2; k >= -2; k--) push_item(k, k == -2);
        // all equal
        for (int k = 0; k < 3; k++) push_item(-32'sd1, k == 2);

        for (int ph = 0; ph < 3; ph++) begin
            // sender holds off until every result of the last phase is out
            drain();
            case (ph)
                0:       begin snd_idle = 12; rcv_idle = 52; end
                1:       begin snd_idle = 52; rcv_idle = 12; end
                default: begin snd_idle = 0;  rcv_idle = 0;  end
            endcase
            left   = PHASE_ITEMS;
            set_no = 0;
            while (left > 0) begin
                // first set exactly full in phase 0, else over by one (final item dropped); third overruns
                if (set_no == 0)      count = (ph == 0) ? SLOTS : SLOTS + 1;
                else if (set_no == 2) count = SLOTS + 6;
                else                  count = pick_size();
                push_set(count);
                left -= count;
                set_no++;
            end
        end

        drain();
        repeat (2 * SLOTS + 20) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));

        $display("insertion_sorter: %0d values loaded in %0d sets, %0d of them over capacity",
                 sb.taken, sb.runs, sb.lossy_runs);
        $display("insertion_sorter: %0d results checked, %0d mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("** insertion_sorter: PASSED **");
        end else begin
            $display("** insertion_sorter: FAILED **");
        end
        $finish;
    end

endmodule
